>>> rtl/core/mmcd_pkg.sv
// Shared constants and types for the min/max column decimator.
// No dependencies.
package mmcd_pkg;

    localparam int X_BITS          = 32;
    localparam int Y_BITS          = 16;
    localparam int COLUMN_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int SCALE_BITS      = 32;
    localparam int CFG_DATA_BITS   = (X_BITS > SCALE_BITS) ? X_BITS : SCALE_BITS;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int PROD_BITS       = X_BITS + SCALE_BITS;
    localparam int PROD_HI_BITS    = PROD_BITS - SCALE_FRAC_BITS;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_X = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE   = 1'd1;

    localparam logic [SCALE_BITS-1:0]  SCALE_RESET = SCALE_BITS'(1677722);
    localparam logic [COLUMN_BITS-1:0] COLUMN_TOP  = {COLUMN_BITS{1'b1}};

    typedef struct packed {
        logic [X_BITS-1:0]        x;
        logic signed [Y_BITS-1:0] y;
    } point_t;

endpackage

>>> rtl/core/min_max_column_decimator.sv
// Timing: an accepted request loads the input/multiply register; if it closes a column,
// the pair output register loads as the sample leaves that register, which can stall
// while the previous pair is still being sent. Throughput: one sample per cycle while no
// column closes; a closing sample puts two results on the single output port, so a closing
// sample waits until the previous pair has gone or its last result is being taken.
// Reset (aresetn, synchronous, active low) clears pipeline, counter, open column and config.
// Depends on mmcd_pkg.
module min_max_column_decimator
    import mmcd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // sample requests
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [X_BITS-1:0]         s_x,
    input  logic signed [Y_BITS-1:0]  s_y,
    // extreme point requests
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [X_BITS-1:0]         m_out_x,
    output logic signed [Y_BITS-1:0]  m_out_y,
    output logic                      m_is_max,
    output logic [COLUMN_BITS-1:0]    m_column,
    output logic                      m_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [X_BITS-1:0]     start_x_reg;
    logic [SCALE_BITS-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            scale_reg   <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data[X_BITS-1:0];
                CFG_SCALE:   scale_reg   <= cfg_data[SCALE_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from the screen edge and the column product.
    // A sample left of start_x is flagged and never closes a column.
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    point_t                s1_pt_reg;
    logic                  s1_neg_reg;
    logic [PROD_BITS-1:0]  s1_prod_reg;

    logic                  in_accept;
    logic [X_BITS-1:0]     in_diff;
    logic [PROD_BITS-1:0]  in_prod;

    assign in_accept = s_valid && s_ready;
    assign in_diff   = s_x - start_x_reg;
    assign in_prod   = PROD_BITS'(in_diff) * PROD_BITS'(scale_reg);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pt_reg.x <= s_x;
            s1_pt_reg.y <= s_y;
            s1_neg_reg  <= (s_x < start_x_reg);
            s1_prod_reg <= in_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: column test against the counter and update of the open column.
    // (product >> frac) >= count, done on the upper product bits.
    // ------------------------------------------------------------------
    logic                    holding_reg, holding_next;
    logic [COLUMN_BITS-1:0]  column_count_reg, column_count_next;
    point_t                  max_pt_reg, max_pt_next;
    point_t                  min_pt_reg, min_pt_next;

    // Pair output register: out_cnt_reg is the number of results still to send
    logic [1:0]              out_cnt_reg, out_cnt_next;
    point_t                  first_pt_reg, second_pt_reg;
    logic                    first_is_max_reg;
    logic [COLUMN_BITS-1:0]  pair_column_reg;

    logic [PROD_HI_BITS-1:0] prod_hi;
    logic                    close_now;
    logic                    pair_free;
    logic                    fire;
    logic                    out_accept;

    assign prod_hi    = s1_prod_reg[PROD_BITS-1:SCALE_FRAC_BITS];
    assign close_now  = s1_valid_reg && holding_reg && !s1_neg_reg
                        && (prod_hi >= PROD_HI_BITS'(column_count_reg));
    assign out_accept = m_valid && m_ready;
    // a new pair may only load once the previous one has gone or is going now
    assign pair_free  = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_ready);
    assign fire       = s1_valid_reg && (!close_now || pair_free);
    assign s_ready    = !s1_valid_reg || fire;

    always_comb begin
        holding_next      = holding_reg;
        column_count_next = column_count_reg;
        max_pt_next       = max_pt_reg;
        min_pt_next       = min_pt_reg;
        out_cnt_next      = out_cnt_reg;

        if (out_accept) begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end

        if (fire) begin
            if (!holding_reg || close_now) begin
                // first sample, or the sample that opens the next column
                holding_next = 1'b1;
                max_pt_next  = s1_pt_reg;
                min_pt_next  = s1_pt_reg;
                if (close_now) begin
                    out_cnt_next = 2'd2;
                    if (column_count_reg != COLUMN_TOP) begin
                        column_count_next = column_count_reg + 1'b1;
                    end
                end
            end else begin
                // strict compares: a tie keeps the held point
                if (s1_pt_reg.y > max_pt_reg.y) begin
                    max_pt_next = s1_pt_reg;
                end
                if (s1_pt_reg.y < min_pt_reg.y) begin
                    min_pt_next = s1_pt_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            holding_reg      <= 1'b0;
            column_count_reg <= '0;
            out_cnt_reg      <= 2'd0;
        end else begin
            s1_valid_reg     <= in_accept || (s1_valid_reg && !fire);
            holding_reg      <= holding_next;
            column_count_reg <= column_count_next;
            out_cnt_reg      <= out_cnt_next;
        end
    end

    // Held extremes only matter once a column is open, so no reset
    always_ff @(posedge aclk) begin
        max_pt_reg <= max_pt_next;
        min_pt_reg <= min_pt_next;
        if (fire && close_now) begin
            // smaller x goes first; equal x sends the minimum first
            if (min_pt_reg.x > max_pt_reg.x) begin
                first_pt_reg     <= max_pt_reg;
                second_pt_reg    <= min_pt_reg;
                first_is_max_reg <= 1'b1;
            end else begin
                first_pt_reg     <= min_pt_reg;
                second_pt_reg    <= max_pt_reg;
                first_is_max_reg <= 1'b0;
            end
            pair_column_reg <= column_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output mux: first point while two remain, then the second
    // ------------------------------------------------------------------
    assign m_valid  = (out_cnt_reg != 2'd0);
    assign m_last   = (out_cnt_reg == 2'd1);
    assign m_out_x  = m_last ? second_pt_reg.x : first_pt_reg.x;
    assign m_out_y  = m_last ? second_pt_reg.y : first_pt_reg.y;
    assign m_is_max = m_last ? !first_is_max_reg : first_is_max_reg;
    assign m_column = pair_column_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the counter only ever steps by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (column_count_reg != $past(column_count_reg))
        |-> (column_count_reg == $past(column_count_reg) + 1'b1))
        else $error("column counter jumped");

    // a pending pair is ordered by x
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == 2'd2) |-> (first_pt_reg.x <= second_pt_reg.x))
        else $error("pair not ordered by x");

    // a pair only loads while a column was open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && close_now) |=> (out_cnt_reg == 2'd2) && holding_reg)
        else $error("pair load without open column");

endmodule
